// ----- hw/rtl/utf8_stream_filter_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Simulation-only property checks. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_FILTER_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_FILTER_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define U8SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8sfd: same-cycle check failed");
`define U8SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8sfd: next-cycle check failed");
`else
`define U8SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define U8SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/u8sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Word types, result kinds, controller/datapath interface and decode tables.
// ----------------------------------------------------------------------------
package u8sfd_pkg;

  localparam int unsigned MAX_TEXT_CHARS = 65536;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned CP_W = 31;
  localparam int unsigned WIN_BYTES = 6;
  localparam int unsigned CNT_W = 3;

  // The character total stops at the parameter or at the largest 17-bit value.
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = (MAX_TEXT_CHARS > 131071) ?
      17'h1FFFF : TOTAL_W'(MAX_TEXT_CHARS);

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DROP = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DEC_NONE = 2'd0,
    DEC_OK   = 2'd1,
    DEC_BAD  = 2'd2
  } dec_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    kind_e               kind;
    logic [CP_W-1:0]     code_point;
    logic [2:0]          byte_count;
    logic [TOTAL_W-1:0]  char_total;
    logic                run_end;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic take;
    logic show;
    logic last;
    logic load_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    dec_e dec;
    logic at_end;
  } sts_t;

  // Indexed by the number of continuation bytes a lead byte asks for.
  localparam logic [7:0] LEAD_BASE [WIN_BYTES] =
      '{8'h00, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC};
  localparam logic [7:0] SECOND_MIN [WIN_BYTES] =
      '{8'h00, 8'h80, 8'hA0, 8'h90, 8'h88, 8'h84};

endpackage

// ----- hw/rtl/u8sfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder controller
// Sequences byte intake, one decode decision at a time and the output word.
// ----------------------------------------------------------------------------
module u8sfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  u8sfd_pkg::sts_t   sts_i,
  output u8sfd_pkg::cmd_t   cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic full_q, full_d;
  logic shown_q, shown_d;
  logic more;

  assign out_valid_o = full_q & shown_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  // Another result follows the one held back in the output register.
  assign more = (sts_i.dec != u8sfd_pkg::DEC_NONE) | sts_i.at_end;

  always_comb begin
    state_d = state_q;
    full_d  = full_q;
    shown_d = shown_q;
    cmd_o   = '0;
    if (out_valid_o && out_ready_i) begin
      full_d  = 1'b0;
      shown_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.append = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A new word is held hidden until it is known whether it is the last.
        priority if (full_q && !shown_q) begin
          cmd_o.show = 1'b1;
          cmd_o.last = ~more;
          shown_d    = 1'b1;
          if (!more) begin
            state_d = ST_IDLE;
          end
        end else if (!full_q) begin
          priority if (sts_i.dec != u8sfd_pkg::DEC_NONE) begin
            cmd_o.take = 1'b1;
            full_d     = 1'b1;
          end else if (sts_i.at_end) begin
            cmd_o.load_end = 1'b1;
            full_d         = 1'b1;
            shown_d        = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      full_q  <= 1'b0;
      shown_q <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
      shown_q <= shown_d;
    end
  end

endmodule

// ----- hw/rtl/u8sfd_datapath.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder datapath
// Byte window, front-of-window decoder, character total and output register.
// ----------------------------------------------------------------------------
module u8sfd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8sfd_pkg::in_t    in_data_i,
  input  u8sfd_pkg::cmd_t   cmd_i,
  output u8sfd_pkg::sts_t   sts_o,
  output u8sfd_pkg::out_t   out_data_o
);

  localparam int unsigned WinW = 8 * u8sfd_pkg::WIN_BYTES;

  logic [WinW-1:0]                  win_q, win_d;
  logic [u8sfd_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [u8sfd_pkg::TOTAL_W-1:0]    tot_q, tot_d, tot_inc;
  logic                             end_q, end_d;
  u8sfd_pkg::out_t                  out_q, out_d;

  logic [7:0]                       b [u8sfd_pkg::WIN_BYTES];
  logic [7:0]                       c0;
  logic [2:0]                       need;
  logic [2:0]                       seq_len;
  logic [u8sfd_pkg::CP_W-1:0]       cp;
  u8sfd_pkg::dec_e                  dec;
  logic                             done;

  always_comb begin
    for (int i = 0; i < int'(u8sfd_pkg::WIN_BYTES); i++) begin
      b[i] = win_q[8*i +: 8];
    end
  end

  // Decision on the sequence at the front of the window.
  always_comb begin
    c0 = b[0];
    if (c0 < 8'hE0) begin
      need = 3'd1;
    end else if (c0 < 8'hF0) begin
      need = 3'd2;
    end else if (c0 < 8'hF8) begin
      need = 3'd3;
    end else if (c0 < 8'hFC) begin
      need = 3'd4;
    end else begin
      need = 3'd5;
    end
    dec  = u8sfd_pkg::DEC_OK;
    done = 1'b0;
    if (cnt_q == '0) begin
      dec  = u8sfd_pkg::DEC_NONE;
      done = 1'b1;
    end else if (c0 < 8'h80) begin
      done = 1'b1;
    end
    // Bytes are checked in order: a missing byte waits, or makes the sequence
    // corrupt at end of text; a non-continuation byte is corrupt.
    for (int n = 1; n < int'(u8sfd_pkg::WIN_BYTES); n++) begin
      if (!done && (3'(n) <= need)) begin
        if (3'(n) >= cnt_q) begin
          dec  = end_q ? u8sfd_pkg::DEC_BAD : u8sfd_pkg::DEC_NONE;
          done = 1'b1;
        end else if (b[n][7:6] != 2'b10) begin
          dec  = u8sfd_pkg::DEC_BAD;
          done = 1'b1;
        end
      end
    end
    if (!done) begin
      if (((need == 3'd1) && (c0 < 8'hC2)) ||
          ((need > 3'd1) && (c0 == u8sfd_pkg::LEAD_BASE[need]) &&
           (b[1] < u8sfd_pkg::SECOND_MIN[need])) ||
          (c0 >= 8'hFE)) begin
        dec = u8sfd_pkg::DEC_BAD;
      end
    end

    if (c0 < 8'h80) begin
      seq_len = 3'd1;
      cp      = {23'd0, c0};
    end else begin
      seq_len = need + 3'd1;
      unique case (need)
        3'd1:    cp = {20'd0, c0[4:0], b[1][5:0]};
        3'd2:    cp = {15'd0, c0[3:0], b[1][5:0], b[2][5:0]};
        3'd3:    cp = {10'd0, c0[2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
        3'd4:    cp = {5'd0, c0[1:0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0]};
        default: cp = {c0[0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0], b[5][5:0]};
      endcase
    end
  end

  assign sts_o.dec    = dec;
  assign sts_o.at_end = end_q;

  assign tot_inc = (tot_q < u8sfd_pkg::TOTAL_CAP) ? tot_q + u8sfd_pkg::TOTAL_W'(1) : tot_q;

  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    tot_d = tot_q;
    end_d = end_q;
    out_d = out_q;
    priority if (cmd_i.append) begin
      for (int i = 0; i < int'(u8sfd_pkg::WIN_BYTES); i++) begin
        if (cnt_q == 3'(i)) begin
          win_d[8*i +: 8] = in_data_i.data_byte;
        end
      end
      cnt_d = cnt_q + u8sfd_pkg::CNT_W'(1);
      end_d = in_data_i.end_of_text;
    end else if (cmd_i.take) begin
      if (dec == u8sfd_pkg::DEC_OK) begin
        tot_d = tot_inc;
        out_d = '{kind: u8sfd_pkg::KIND_CHAR, code_point: cp, byte_count: seq_len,
                  char_total: tot_inc, run_end: 1'b0};
        win_d = win_q >> {seq_len, 3'b000};
        cnt_d = cnt_q - seq_len;
      end else begin
        out_d = '{kind: u8sfd_pkg::KIND_DROP, code_point: {23'd0, c0},
                  byte_count: 3'd0, char_total: tot_q, run_end: 1'b0};
        win_d = win_q >> 8;
        cnt_d = cnt_q - u8sfd_pkg::CNT_W'(1);
      end
    end else if (cmd_i.load_end) begin
      out_d = '{kind: u8sfd_pkg::KIND_END, code_point: '0, byte_count: 3'd0,
                char_total: tot_q, run_end: 1'b1};
      tot_d = '0;
      cnt_d = '0;
    end else if (cmd_i.show) begin
      out_d.run_end = cmd_i.last;
    end else begin
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tot_q <= '0;
      end_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      tot_q <= tot_d;
      end_q <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ----- hw/rtl/utf8_stream_filter_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream filter decoder
// Decodes a byte stream into code points, drops corrupt bytes, counts chars.
// ----------------------------------------------------------------------------
// Each accepted byte enters a six-byte window and the decoder then makes one
// decision at a time on the front of the window: a whole character, a dropped
// corrupt byte, or nothing further until more bytes arrive. Each result word is
// held hidden in the output register until its run_end flag is known, and only
// then shown. A byte that releases no result passes through intake and a
// decision. A byte that completes a character passes through intake, decision
// and release before the next byte can be taken, and each further result adds
// the steps of waiting for the shown word to be taken, decision and release; at
// end of text the end word adds waiting and load. Each stall of a shown word on
// the output side lengthens the wait. These steps follow from the single
// decision step and the one output register. A new byte is taken whenever the
// decoder is idle, even while the last result still waits to be taken.
// ----------------------------------------------------------------------------
`include "utf8_stream_filter_decoder_unit_assert.svh"

module utf8_stream_filter_decoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  u8sfd_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u8sfd_pkg::out_t   out_data_o
);

  u8sfd_pkg::cmd_t cmd;
  u8sfd_pkg::sts_t sts;

  u8sfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u8sfd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  `U8SFD_ASSERT_IMPL(a_end_is_last, clk_i, rst_ni,
                     out_valid_o && (out_data_o.kind == u8sfd_pkg::KIND_END),
                     out_data_o.run_end)
  `U8SFD_ASSERT_IMPL(a_char_counted, clk_i, rst_ni,
                     out_valid_o && (out_data_o.kind == u8sfd_pkg::KIND_CHAR),
                     out_data_o.char_total != '0)
  `U8SFD_ASSERT_IMPL(a_len_matches_kind, clk_i, rst_ni, out_valid_o,
                     (out_data_o.kind == u8sfd_pkg::KIND_CHAR) == (out_data_o.byte_count != 3'd0))
  `U8SFD_ASSERT_NEXT(a_scan_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule
